// File: hdl/hapc_pkg.sv
// ----------------------------------------------------------------------------
// hapc_pkg
// Shared widths, constants, types and the arctangent table used by the
// heading pipeline.
// ----------------------------------------------------------------------------
package hapc_pkg;

	// angle and coordinate formats
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int COORD_BITS      = 24;
	localparam int HEADING_BITS    = 16;

	// difference and magnitude widths
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int MAG_BITS   = COORD_BITS;
	localparam int NEAR_LIMIT = 2;
	localparam int NUDGE      = 128;

	// normalization: larger magnitude lands in [2^NORM_TOP, 2^(NORM_TOP+1))
	localparam int NORM_TOP  = 40;
	localparam int NORM_BITS = NORM_TOP + 1;
	localparam int SH_BITS   = $clog2(NORM_TOP + 1);

	// cordic datapath
	localparam int CORDIC_STEPS = 28;
	localparam int CW           = NORM_TOP + 5;
	localparam int ZFRAC        = 24;
	localparam int Z_BITS       = ZFRAC + 9;
	localparam logic [Z_BITS-1:0] Z_MAX = Z_BITS'(90) << ZFRAC;

	// rounding of the base angle
	localparam int ROUND_SHIFT = ZFRAC - ANGLE_FRAC_BITS;
	localparam logic [Z_BITS-1:0] Z_RND = Z_BITS'(1) << (ROUND_SHIFT - 1);
	localparam int A_BITS = $clog2((90 << ANGLE_FRAC_BITS) + 1);

	// quadrant mapping
	localparam int FULL_ANG = 360 << ANGLE_FRAC_BITS;
	localparam int HALF_ANG = 180 << ANGLE_FRAC_BITS;
	localparam int R_BITS   = $clog2(FULL_ANG + 1);

	// cycles from an accepted transaction to its result strobe
	localparam int LATENCY = CORDIC_STEPS + 6;

	// which side of each axis the target lies on
	typedef struct packed {
		logic dx_pos;
		logic dy_pos;
	} quad_t;

	// atan(2^-i) in units of 2^-24 degree
	function automatic logic signed [Z_BITS-1:0] atan_entry(input int idx);
		logic signed [Z_BITS-1:0] v;
		case (idx)
			0:       v = Z_BITS'(754974720);
			1:       v = Z_BITS'(445687602);
			2:       v = Z_BITS'(235489088);
			3:       v = Z_BITS'(119537938);
			4:       v = Z_BITS'(60000935);
			5:       v = Z_BITS'(30029717);
			6:       v = Z_BITS'(15018523);
			7:       v = Z_BITS'(7509719);
			8:       v = Z_BITS'(3754917);
			9:       v = Z_BITS'(1877466);
			10:      v = Z_BITS'(938734);
			11:      v = Z_BITS'(469367);
			12:      v = Z_BITS'(234684);
			13:      v = Z_BITS'(117342);
			14:      v = Z_BITS'(58671);
			15:      v = Z_BITS'(29335);
			16:      v = Z_BITS'(14668);
			17:      v = Z_BITS'(7334);
			18:      v = Z_BITS'(3667);
			19:      v = Z_BITS'(1833);
			20:      v = Z_BITS'(917);
			21:      v = Z_BITS'(458);
			22:      v = Z_BITS'(229);
			23:      v = Z_BITS'(115);
			24:      v = Z_BITS'(57);
			25:      v = Z_BITS'(29);
			26:      v = Z_BITS'(14);
			27:      v = Z_BITS'(7);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/hapc_cordic.sv
// ----------------------------------------------------------------------------
// hapc_cordic
// Fully pipelined cordic vectoring unit, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module hapc_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [hapc_pkg::CW-1:0]     in_x,
	input  logic signed [hapc_pkg::CW-1:0]     in_y,
	input  hapc_pkg::quad_t                    in_quad,
	output logic                               out_valid,
	output logic signed [hapc_pkg::Z_BITS-1:0] out_z,
	output hapc_pkg::quad_t                    out_quad
);

	localparam int N = hapc_pkg::CORDIC_STEPS;
	localparam int W = hapc_pkg::CW;
	localparam int ZB = hapc_pkg::Z_BITS;

	// entry k of each array is the register after micro-rotation k-1; entry 0 is the input
	logic signed [W-1:0]  cx_s [0:N];
	logic signed [W-1:0]  cy_s [0:N];
	logic signed [ZB-1:0] cz_s [0:N];
	hapc_pkg::quad_t      cq_s [0:N];
	logic                 cv_s [0:N];

	assign cx_s[0] = in_x;
	assign cy_s[0] = in_y;
	assign cz_s[0] = '0;
	assign cq_s[0] = in_quad;
	assign cv_s[0] = in_valid;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic signed [W-1:0] BIAS = (W'(1) << k) - W'(1);
		localparam logic signed [ZB-1:0] ANG = hapc_pkg::atan_entry(k);

		logic signed [W-1:0] xs;
		logic signed [W-1:0] ys;
		logic                y_pos;

		// shifted terms, y rounds toward zero when negative
		always_comb begin
			xs    = cx_s[k] >>> k;
			ys    = (cy_s[k] + (cy_s[k][W-1] ? BIAS : W'(0))) >>> k;
			y_pos = !cy_s[k][W-1] && (cy_s[k] != '0);
		end

		// valid bit of this stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[k+1] <= 1'b0;
			end else begin
				cv_s[k+1] <= cv_s[k];
			end
		end

		// micro-rotation toward the x axis
		always_ff @(posedge clk) begin
			cq_s[k+1] <= cq_s[k];
			if (y_pos) begin
				cx_s[k+1] <= cx_s[k] + ys;
				cy_s[k+1] <= cy_s[k] - xs;
				cz_s[k+1] <= cz_s[k] + ANG;
			end else begin
				cx_s[k+1] <= cx_s[k] - ys;
				cy_s[k+1] <= cy_s[k] + xs;
				cz_s[k+1] <= cz_s[k] - ANG;
			end
		end
	end

	assign out_valid = cv_s[N];
	assign out_z     = cz_s[N];
	assign out_quad  = cq_s[N];

endmodule

// File: hdl/heading_angle_from_points_core.sv
// Path: a transaction accepted by start gives its done strobe after the 4 front stages,
// one stage per cordic micro-rotation, and the clamp/round and quadrant stages.
// Throughput: one transaction per cycle; busy is always low, the pipeline never stalls.
// Reset: arst_n clears all valid bits at once; no results appear until new transactions.
// ----------------------------------------------------------------------------
// heading_angle_from_points_core
// Clockwise heading from a start point to a target point, in 1/128 degree,
// through a pipelined cordic vectoring unit.
// ----------------------------------------------------------------------------
module heading_angle_from_points_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [hapc_pkg::COORD_BITS-1:0]  start_x,
	input  logic signed [hapc_pkg::COORD_BITS-1:0]  start_y,
	input  logic signed [hapc_pkg::COORD_BITS-1:0]  target_x,
	input  logic signed [hapc_pkg::COORD_BITS-1:0]  target_y,
	output logic                                    done,
	output logic        [hapc_pkg::HEADING_BITS-1:0] heading
);

	localparam int DB = hapc_pkg::DIFF_BITS;
	localparam int CB = hapc_pkg::COORD_BITS;
	localparam int MB = hapc_pkg::MAG_BITS;
	localparam int ZB = hapc_pkg::Z_BITS;
	localparam int RB = hapc_pkg::R_BITS;
	localparam logic signed [DB-1:0] NEAR_D  = DB'(hapc_pkg::NEAR_LIMIT);
	localparam logic signed [DB-1:0] NUDGE_D = DB'(hapc_pkg::NUDGE);
	localparam logic [RB-1:0] FULL_R = RB'(hapc_pkg::FULL_ANG);
	localparam logic [RB-1:0] HALF_R = RB'(hapc_pkg::HALF_ANG);

	// stage 1: coordinate differences
	logic                 valid_s1;
	logic signed [DB-1:0] dx_s1;
	logic signed [DB-1:0] dy_s1;

	// stage 2: nudge, magnitudes and sides
	logic                 valid_s2;
	logic [MB-1:0]        ax_s2;
	logic [MB-1:0]        ay_s2;
	hapc_pkg::quad_t      quad_s2;

	// stage 3: normalizing shift amount
	logic                           valid_s3;
	logic [MB-1:0]                  ax_s3;
	logic [MB-1:0]                  ay_s3;
	logic [hapc_pkg::SH_BITS-1:0]   sh_s3;
	hapc_pkg::quad_t                quad_s3;

	// stage 4: normalized cordic inputs
	logic                           valid_s4;
	logic signed [hapc_pkg::CW-1:0] nx_s4;
	logic signed [hapc_pkg::CW-1:0] ny_s4;
	hapc_pkg::quad_t                quad_s4;

	// cordic outputs
	logic                 cor_valid;
	logic signed [ZB-1:0] cor_z;
	hapc_pkg::quad_t      cor_quad;

	// stage 33: base angle; stage 34: heading
	logic                          valid_s33;
	logic [hapc_pkg::A_BITS-1:0]   ang_s33;
	hapc_pkg::quad_t               quad_s33;
	logic                          valid_s34;
	logic [hapc_pkg::HEADING_BITS-1:0] heading_s34;

	assign busy = 1'b0;

	// valid chain of the front stages and the back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s33 <= 1'b0;
			valid_s34 <= 1'b0;
		end else begin
			valid_s1  <= start && !busy;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s33 <= cor_valid;
			valid_s34 <= valid_s33;
		end
	end

	// differences, sign extended by one bit
	always_ff @(posedge clk) begin
		dx_s1 <= $signed({target_x[CB-1], target_x}) - $signed({start_x[CB-1], start_x});
		dy_s1 <= $signed({target_y[CB-1], target_y}) - $signed({start_y[CB-1], start_y});
	end

	// near-vertical nudge folded into the absolute value
	logic                 near_x;
	logic signed [DB-1:0] ax_full;
	logic signed [DB-1:0] ay_full;

	always_comb begin
		near_x  = (dx_s1 >= -NEAR_D) && (dx_s1 <= NEAR_D);
		if (near_x) begin
			ax_full = NUDGE_D - dx_s1;
		end else if (dx_s1[DB-1]) begin
			ax_full = -dx_s1;
		end else begin
			ax_full = dx_s1;
		end
		ay_full = dy_s1[DB-1] ? -dy_s1 : dy_s1;
	end

	always_ff @(posedge clk) begin
		ax_s2          <= ax_full[MB-1:0];
		ay_s2          <= ay_full[MB-1:0];
		quad_s2.dx_pos <= !near_x && !dx_s1[DB-1];
		quad_s2.dy_pos <= !dy_s1[DB-1] && (dy_s1 != '0);
	end

	// leading one of the larger magnitude
	logic [MB-1:0]                big;
	logic [hapc_pkg::SH_BITS-1:0] msb;

	always_comb begin
		big = (ax_s2 > ay_s2) ? ax_s2 : ay_s2;
		msb = '0;
		for (int b = 0; b < MB; b++) begin
			if (big[b]) begin
				msb = hapc_pkg::SH_BITS'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		ax_s3   <= ax_s2;
		ay_s3   <= ay_s2;
		sh_s3   <= hapc_pkg::SH_BITS'(hapc_pkg::NORM_TOP) - msb;
		quad_s3 <= quad_s2;
	end

	// normalizing shift of both magnitudes
	logic [hapc_pkg::NORM_BITS-1:0] nx;
	logic [hapc_pkg::NORM_BITS-1:0] ny;

	always_comb begin
		nx = hapc_pkg::NORM_BITS'(ax_s3) << sh_s3;
		ny = hapc_pkg::NORM_BITS'(ay_s3) << sh_s3;
	end

	always_ff @(posedge clk) begin
		nx_s4   <= $signed(hapc_pkg::CW'(nx));
		ny_s4   <= $signed(hapc_pkg::CW'(ny));
		quad_s4 <= quad_s3;
	end

	hapc_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.in_x      (nx_s4),
		.in_y      (ny_s4),
		.in_quad   (quad_s4),
		.out_valid (cor_valid),
		.out_z     (cor_z),
		.out_quad  (cor_quad)
	);

	// clamp to 0..90 degrees and round half up
	logic [ZB-1:0] z_clamp;
	logic [ZB-1:0] z_round;

	always_comb begin
		if (cor_z[ZB-1]) begin
			z_clamp = '0;
		end else if ($unsigned(cor_z) > hapc_pkg::Z_MAX) begin
			z_clamp = hapc_pkg::Z_MAX;
		end else begin
			z_clamp = $unsigned(cor_z);
		end
		z_round = z_clamp + hapc_pkg::Z_RND;
	end

	always_ff @(posedge clk) begin
		ang_s33  <= z_round[hapc_pkg::ROUND_SHIFT +: hapc_pkg::A_BITS];
		quad_s33 <= cor_quad;
	end

	// quadrant mapping and full-circle wrap
	logic [RB-1:0] ang_r;
	logic [RB-1:0] head_raw;
	logic [RB-1:0] head_wrap;

	always_comb begin
		ang_r = RB'(ang_s33);
		if (quad_s33.dy_pos) begin
			head_raw = quad_s33.dx_pos ? (FULL_R - ang_r) : (HALF_R + ang_r);
		end else begin
			head_raw = quad_s33.dx_pos ? ang_r : (HALF_R - ang_r);
		end
		head_wrap = (head_raw >= FULL_R) ? (head_raw - FULL_R) : head_raw;
	end

	always_ff @(posedge clk) begin
		heading_s34 <= hapc_pkg::HEADING_BITS'(head_wrap);
	end

	assign done    = valid_s34;
	assign heading = heading_s34;

endmodule

// File: hdl/hapc_checker.sv
// ----------------------------------------------------------------------------
// hapc_checker
// Port-level checks of the heading core: fixed latency and result range.
// ----------------------------------------------------------------------------
module hapc_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     start,
	input logic                                     busy,
	input logic                                     done,
	input logic [hapc_pkg::HEADING_BITS-1:0]        heading
);

	localparam int L = hapc_pkg::LATENCY;
	localparam int CNT_BITS = $clog2(L + 1);
	localparam int LIMIT = (hapc_pkg::FULL_ANG > (1 << hapc_pkg::HEADING_BITS)) ?
		(1 << hapc_pkg::HEADING_BITS) : hapc_pkg::FULL_ANG;

	// cycles since reset release, saturating at the latency
	logic [CNT_BITS-1:0] since_rst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_rst_q <= '0;
		end else if (since_rst_q != CNT_BITS'(L)) begin
			since_rst_q <= since_rst_q + CNT_BITS'(1);
		end
	end

	// every accepted transaction gives a strobe after the fixed latency
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(since_rst_q == CNT_BITS'(L)) && $past(start && !busy, L) |-> done)
		else $error("accepted transaction without result after latency");

	// every strobe traces back to a transaction accepted one latency earlier
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (since_rst_q == CNT_BITS'(L)) && $past(start && !busy, L))
		else $error("result strobe without matching transaction");

	// heading stays below a full circle
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(heading) < 32'(LIMIT)))
		else $error("heading out of range");

endmodule

bind heading_angle_from_points_core hapc_checker u_hapc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.heading (heading)
);
